>>> rtl/bft_pkg.sv
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types and codes for the bidirectional flow totalizer.
// ----------------------------------------------------------------------------
package bft_pkg;

	localparam int NET_W   = 49;
	localparam int ABS_W   = 42;
	localparam int MILLI_W = 10;

	// lifetime total is in milli m3, sums in mL
	localparam logic [MILLI_W-1:0] MILLI_L_PER_M3 = 10'd1000;

	// request kinds on the input channel
	localparam logic [1:0] FN_SAMPLE = 2'd0;
	localparam logic [1:0] FN_EDGE   = 2'd1;
	localparam logic [1:0] FN_RESET  = 2'd2;

	// decoded direction
	localparam logic [1:0] DIR_UNKNOWN = 2'd0;
	localparam logic [1:0] DIR_IN      = 2'd1;
	localparam logic [1:0] DIR_OUT     = 2'd2;

	// result outcome codes
	localparam logic [3:0] OC_BASELINE  = 4'd0;
	localparam logic [3:0] OC_RST_DONE  = 4'd1;
	localparam logic [3:0] OC_REBASE    = 4'd2;
	localparam logic [3:0] OC_EDGE_AMB  = 4'd3;
	localparam logic [3:0] OC_CHG_AMB   = 4'd4;
	localparam logic [3:0] OC_INFLOW    = 4'd5;
	localparam logic [3:0] OC_OUTFLOW   = 4'd6;
	localparam logic [3:0] OC_EDGE      = 4'd7;
	localparam logic [3:0] OC_RST_REQ   = 4'd8;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  dir;
		logic [31:0] now_ms;
		logic [31:0] batch;
		logic [31:0] total;
		logic [31:0] seq;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> rtl/bft_ifs.sv
// ----------------------------------------------------------------------------
// bft channel interfaces
// Input request, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bft_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] now_ms;
	logic [31:0] batch_ml;
	logic [31:0] meter_total_milli_m3;
	logic        pin_level;
	logic [31:0] event_sequence;

	modport src (output valid, func, now_ms, batch_ml, meter_total_milli_m3,
		pin_level, event_sequence, input ready);
	modport snk (input valid, func, now_ms, batch_ml, meter_total_milli_m3,
		pin_level, event_sequence, output ready);
endinterface

interface bft_res_if import bft_pkg::*; #(parameter int SUM_WIDTH = 48);
	logic                    valid;
	logic                    ready;
	logic [SUM_WIDTH-1:0]    inflow_sum;
	logic [SUM_WIDTH-1:0]    outflow_sum;
	logic [SUM_WIDTH-1:0]    unclassified_sum;
	logic signed [NET_W-1:0] net_volume;
	logic [ABS_W-1:0]        meter_absolute;
	logic [31:0]             reset_count;
	logic [31:0]             reset_time_ms;
	logic [3:0]              outcome;
	logic [31:0]             missed_events;
	logic                    boundary_pending;
	logic                    rst_pending;
	logic [1:0]              direction;

	modport src (output valid, inflow_sum, outflow_sum, unclassified_sum, net_volume,
		meter_absolute, reset_count, reset_time_ms, outcome, missed_events,
		boundary_pending, rst_pending, direction, input ready);
	modport snk (input valid, inflow_sum, outflow_sum, unclassified_sum, net_volume,
		meter_absolute, reset_count, reset_time_ms, outcome, missed_events,
		boundary_pending, rst_pending, direction, output ready);
endinterface

interface bft_cfg_if;
	logic valid;
	logic ready;
	logic inflow_pin;

	modport src (output valid, inflow_pin, input ready);
	modport snk (input valid, inflow_pin, output ready);
endinterface

>>> rtl/bidirectional_flow_totalizer.sv
// ----------------------------------------------------------------------------
// bidirectional_flow_totalizer
// Splits meter volume into inflow, outflow and unclassified session sums.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   func, now_ms, batch/meter totals, level, seq
//   res      out  valid/ready   sums, net, absolute, reset info, outcome, flags
//   cfg      in   valid/ready   inflow_pin (ready tied high)
//
// One request per cycle sustained while the result side takes results; each
// request passes through the queue and then the result register. The back
// end's single state-update stage sets that rate. A two-entry queue and the result
// register let either side stall without losing requests. Reset clears all
// baselines, sums and flags at once; func code 3 is taken with no result.
// ----------------------------------------------------------------------------
module bidirectional_flow_totalizer import bft_pkg::*; #(
	parameter int SUM_WIDTH = 48
) (
	input  logic   clk,
	input  logic   arst_n,
	bft_in_if.snk  req,
	bft_res_if.src res,
	bft_cfg_if.snk cfg
);

	qstat_t qstat;
	logic   push;
	logic   pop;
	cmd_t   wr_cmd;
	cmd_t   rd_cmd;

	bft_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.qstat  (qstat),
		.push   (push),
		.cmd    (wr_cmd)
	);

	bft_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.qstat  (qstat)
	);

	bft_back #(.SUM_WIDTH(SUM_WIDTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.cmd    (rd_cmd),
		.pop    (pop),
		.res    (res)
	);

	a_rst_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.outcome == OC_RST_DONE |->
		!res.rst_pending && !res.boundary_pending && res.unclassified_sum == '0 &&
		res.net_volume == '0)
		else $error("applied reset left state behind");

	a_missed_only_edge: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.missed_events != '0 |-> res.outcome == OC_EDGE)
		else $error("missed events on a non-edge result");

	a_class_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.outcome == OC_INFLOW || res.outcome == OC_OUTFLOW) |->
		res.direction == ((res.outcome == OC_INFLOW) ? DIR_IN : DIR_OUT) &&
		!res.boundary_pending)
		else $error("classified sample disagrees with direction");

	a_pop_needs_queue: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("back end took from an empty queue");

endmodule

>>> rtl/bft_front.sv
// ----------------------------------------------------------------------------
// bft_front
// Accepts requests, drops unused codes, decodes direction, feeds the queue.
// ----------------------------------------------------------------------------
module bft_front import bft_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bft_in_if.snk        req,
	bft_cfg_if.snk       cfg,
	input  qstat_t       qstat,
	output logic         push,
	output cmd_t         cmd
);

	logic inflow_pin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflow_pin_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			inflow_pin_q <= cfg.inflow_pin;
		end
	end

	assign cfg.ready = 1'b1;
	assign req.ready = !qstat.full;

	// unused code is taken and discarded
	assign push = req.valid && !qstat.full &&
		(req.func inside {FN_SAMPLE, FN_EDGE, FN_RESET});

	always_comb begin
		cmd.func   = req.func;
		cmd.dir    = (req.pin_level == inflow_pin_q) ? DIR_IN : DIR_OUT;
		cmd.now_ms = req.now_ms;
		cmd.batch  = req.batch_ml;
		cmd.total  = req.meter_total_milli_m3;
		cmd.seq    = req.event_sequence;
	end

endmodule

>>> rtl/bft_queue.sv
// ----------------------------------------------------------------------------
// bft_queue
// Two-entry queue of decoded requests between front and back.
// ----------------------------------------------------------------------------
module bft_queue import bft_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   wr_cmd,
	input  logic   pop,
	output cmd_t   rd_cmd,
	output qstat_t qstat
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_cmd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/bft_back.sv
// ----------------------------------------------------------------------------
// bft_back
// Applies queued requests to baselines and session sums; holds the result.
// ----------------------------------------------------------------------------
module bft_back import bft_pkg::*; #(
	parameter int SUM_WIDTH = 48
) (
	input  logic   clk,
	input  logic   arst_n,
	input  qstat_t qstat,
	input  cmd_t   cmd,
	output logic   pop,
	bft_res_if.src res
);

	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

	// state
	logic [31:0]          last_batch_q, total_base_q, last_seq_q;
	logic [1:0]           acct_dir_q, edge_dir_q, cur_dir_q;
	logic                 base_q, tbase_q, bound_q, rstp_q;
	logic [SUM_WIDTH-1:0] in_sum_q, out_sum_q, unc_sum_q;
	logic [NET_W-1:0]     net_q;
	logic [ABS_W-1:0]     abs_q;
	logic [31:0]          rst_cnt_q, rst_time_q;
	logic                 res_valid_q;
	logic [3:0]           outcome_q;
	logic [31:0]          missed_q;

	// next state
	logic [31:0]          last_batch_n, total_base_n, last_seq_n;
	logic [1:0]           acct_dir_n, edge_dir_n, cur_dir_n;
	logic                 base_n, tbase_n, bound_n, rstp_n;
	logic [SUM_WIDTH-1:0] in_sum_n, out_sum_n, unc_sum_n;
	logic [NET_W-1:0]     net_n;
	logic [ABS_W-1:0]     abs_n;
	logic [31:0]          rst_cnt_n, rst_time_n;
	logic [3:0]           outcome_n;
	logic [31:0]          missed_n;

	// shared saturating adder and helpers
	logic [31:0]          delta;
	logic [1:0]           tgt;
	logic [SUM_WIDTH-1:0] tgt_sum;
	logic [SUM_WIDTH:0]   add_wide;
	logic [SUM_WIDTH-1:0] sat_sum;
	logic [31:0]          tot_diff;
	logic [ABS_W-1:0]     tot_milli;
	logic [31:0]          gap;

	assign pop = !qstat.empty && (!res_valid_q || res.ready);

	assign delta    = cmd.batch - last_batch_q;
	assign tgt      = (bound_q || cmd.dir != acct_dir_q) ? DIR_UNKNOWN : cmd.dir;
	assign tgt_sum  = (tgt == DIR_IN) ? in_sum_q : (tgt == DIR_OUT) ? out_sum_q : unc_sum_q;
	assign add_wide = {1'b0, tgt_sum} + {{(SUM_WIDTH + 1 - 32){1'b0}}, delta};
	assign sat_sum  = add_wide[SUM_WIDTH] ? SUM_MAX : add_wide[SUM_WIDTH-1:0];
	assign tot_diff = cmd.total - total_base_q;
	assign tot_milli = {{(ABS_W - 32){1'b0}}, tot_diff} * {{(ABS_W - MILLI_W){1'b0}},
		MILLI_L_PER_M3};
	assign gap      = cmd.seq - last_seq_q;

	always_comb begin
		last_batch_n = last_batch_q;
		total_base_n = total_base_q;
		last_seq_n   = last_seq_q;
		acct_dir_n   = acct_dir_q;
		edge_dir_n   = edge_dir_q;
		cur_dir_n    = cur_dir_q;
		base_n       = base_q;
		tbase_n      = tbase_q;
		bound_n      = bound_q;
		rstp_n       = rstp_q;
		in_sum_n     = in_sum_q;
		out_sum_n    = out_sum_q;
		unc_sum_n    = unc_sum_q;
		abs_n        = abs_q;
		rst_cnt_n    = rst_cnt_q;
		rst_time_n   = rst_time_q;
		outcome_n    = OC_RST_REQ;
		missed_n     = '0;

		case (cmd.func)
			FN_SAMPLE: begin
				cur_dir_n = cmd.dir;
				if (rstp_q) begin
					in_sum_n     = '0;
					out_sum_n    = '0;
					unc_sum_n    = '0;
					rst_cnt_n    = rst_cnt_q + 1'b1;
					rst_time_n   = cmd.now_ms;
					last_batch_n = cmd.batch;
					acct_dir_n   = cmd.dir;
					total_base_n = cmd.total;
					tbase_n      = 1'b1;
					abs_n        = '0;
					base_n       = 1'b1;
					rstp_n       = 1'b0;
					bound_n      = 1'b0;
					outcome_n    = OC_RST_DONE;
				end else begin
					if (!tbase_q || cmd.total < total_base_q) begin
						total_base_n = cmd.total;
						tbase_n      = 1'b1;
						abs_n        = '0;
					end else begin
						abs_n = tot_milli;
					end
					last_batch_n = cmd.batch;
					if (!base_q) begin
						acct_dir_n = cmd.dir;
						base_n     = 1'b1;
						outcome_n  = OC_BASELINE;
					end else if (cmd.batch < last_batch_q) begin
						acct_dir_n = cmd.dir;
						bound_n    = 1'b0;
						outcome_n  = OC_REBASE;
					end else if (bound_q) begin
						unc_sum_n  = sat_sum;
						acct_dir_n = edge_dir_q;
						bound_n    = 1'b0;
						outcome_n  = OC_EDGE_AMB;
					end else if (cmd.dir != acct_dir_q) begin
						unc_sum_n  = sat_sum;
						acct_dir_n = cmd.dir;
						outcome_n  = OC_CHG_AMB;
					end else if (cmd.dir == DIR_IN) begin
						in_sum_n  = sat_sum;
						outcome_n = OC_INFLOW;
					end else begin
						out_sum_n = sat_sum;
						outcome_n = OC_OUTFLOW;
					end
				end
			end
			FN_EDGE: begin
				last_seq_n = cmd.seq;
				missed_n   = (gap == '0) ? '0 : gap - 1'b1;
				cur_dir_n  = cmd.dir;
				if (base_q) begin
					edge_dir_n = cmd.dir;
					bound_n    = 1'b1;
				end
				outcome_n = OC_EDGE;
			end
			FN_RESET: begin
				rstp_n    = 1'b1;
				outcome_n = OC_RST_REQ;
			end
			default: begin
				outcome_n = OC_RST_REQ;
			end
		endcase
	end

	// net follows the sums on reset and on classified samples only
	always_comb begin
		net_n = net_q;
		if (cmd.func == FN_SAMPLE && (rstp_q || outcome_n == OC_INFLOW ||
			outcome_n == OC_OUTFLOW)) begin
			net_n = NET_W'(in_sum_n) - NET_W'(out_sum_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_batch_q <= '0;
			total_base_q <= '0;
			last_seq_q   <= '0;
			acct_dir_q   <= DIR_UNKNOWN;
			edge_dir_q   <= DIR_UNKNOWN;
			cur_dir_q    <= DIR_UNKNOWN;
			base_q       <= 1'b0;
			tbase_q      <= 1'b0;
			bound_q      <= 1'b0;
			rstp_q       <= 1'b0;
			in_sum_q     <= '0;
			out_sum_q    <= '0;
			unc_sum_q    <= '0;
			net_q        <= '0;
			abs_q        <= '0;
			rst_cnt_q    <= '0;
			rst_time_q   <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				last_batch_q <= last_batch_n;
				total_base_q <= total_base_n;
				last_seq_q   <= last_seq_n;
				acct_dir_q   <= acct_dir_n;
				edge_dir_q   <= edge_dir_n;
				cur_dir_q    <= cur_dir_n;
				base_q       <= base_n;
				tbase_q      <= tbase_n;
				bound_q      <= bound_n;
				rstp_q       <= rstp_n;
				in_sum_q     <= in_sum_n;
				out_sum_q    <= out_sum_n;
				unc_sum_q    <= unc_sum_n;
				net_q        <= net_n;
				abs_q        <= abs_n;
				rst_cnt_q    <= rst_cnt_n;
				rst_time_q   <= rst_time_n;
				res_valid_q  <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			outcome_q <= outcome_n;
			missed_q  <= missed_n;
		end
	end

	// state only moves on pop, so it stands as the held result
	assign res.valid            = res_valid_q;
	assign res.inflow_sum       = in_sum_q;
	assign res.outflow_sum      = out_sum_q;
	assign res.unclassified_sum = unc_sum_q;
	assign res.net_volume       = net_q;
	assign res.meter_absolute   = abs_q;
	assign res.reset_count      = rst_cnt_q;
	assign res.reset_time_ms    = rst_time_q;
	assign res.outcome          = outcome_q;
	assign res.missed_events    = missed_q;
	assign res.boundary_pending = bound_q;
	assign res.rst_pending      = rstp_q;
	assign res.direction        = cur_dir_q;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives meter samples, direction edges and session resets into the flow
// totalizer and checks every result against a cycle-free model of the sums,
// baselines and pending flags. A directed table comes first, then random
// traffic under two inflow settings, then a run of full-scale inflow deltas
// with no idling.
// ----------------------------------------------------------------------------
module tb_top import bft_pkg::*; ();

	localparam int SW    = 48;
	localparam int LIMIT = 600000;
	localparam int NDIR  = 23;
	localparam int NSAT  = 150;

	typedef struct packed {
		logic [1:0]  fn;
		logic [31:0] now;
		logic [31:0] batch;
		logic [31:0] total;
		logic        lvl;
		logic [31:0] seq;
	} req_t;

	typedef struct packed {
		req_t        rq;
		logic        typed;
		logic [3:0]  oc;
		logic [31:0] miss;
	} row_t;

	typedef struct {
		logic [SW-1:0]    inflow;
		logic [SW-1:0]    outflow;
		logic [SW-1:0]    unclass;
		logic [NET_W-1:0] net;
		logic [ABS_W-1:0] absv;
		logic [31:0]      clears;
		logic [31:0]      clear_time;
		logic [3:0]       oc;
		logic [31:0]      missed;
		logic             bound;
		logic             rst;
		logic [1:0]       dir;
	} tally_t;

	logic clk;
	logic arst_n = 1'b0;

	bft_in_if                      req_if();
	bft_res_if #(.SUM_WIDTH(SW))   res_if();
	bft_cfg_if                     cfg_if();

	bidirectional_flow_totalizer #(.SUM_WIDTH(SW)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// model state
	logic [31:0]      base_batch = '0;
	logic [31:0]      base_total = '0;
	logic [31:0]      seq_seen   = '0;
	logic [1:0]       acct_dir   = DIR_UNKNOWN;
	logic [1:0]       edge_dir   = DIR_UNKNOWN;
	logic [1:0]       cur_dir    = DIR_UNKNOWN;
	logic             batch_ok   = 1'b0;
	logic             total_ok   = 1'b0;
	logic             edge_pend  = 1'b0;
	logic             clear_pend = 1'b0;
	logic [SW-1:0]    in_sum     = '0;
	logic [SW-1:0]    out_sum    = '0;
	logic [SW-1:0]    amb_sum    = '0;
	logic [NET_W-1:0] net_acc    = '0;
	logic [ABS_W-1:0] abs_acc    = '0;
	logic [31:0]      clears     = '0;
	logic [31:0]      clear_time = '0;
	logic             inflow_cfg = 1'b0;

	tally_t tally_q[$];
	int     errs    = 0;
	int     results = 0;
	int     ticks   = 0;
	bit     idle_on = 1'b1;

	logic [31:0] g_batch = '0;
	logic [31:0] g_total = '0;
	logic [31:0] g_seq   = '0;
	logic        g_lvl   = 1'b0;

	row_t plan [NDIR] = '{
		'{'{FN_EDGE,   32'd0, 32'd0, 32'd0, 1'b0, 32'd5}, 1'b1, OC_EDGE, 32'd4},
		'{'{FN_SAMPLE, 32'd0, 32'd100, 32'd10, 1'b0, 32'd0}, 1'b1, OC_BASELINE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'd300, 32'd12, 1'b0, 32'd0}, 1'b0, OC_BASELINE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'd400, 32'd12, 1'b1, 32'd0}, 1'b0, OC_BASELINE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'd900, 32'd13, 1'b1, 32'd0}, 1'b0, OC_BASELINE, 32'd0},
		'{'{FN_EDGE,   32'd0, 32'd0, 32'd0, 1'b0, 32'd5}, 1'b1, OC_EDGE, 32'd0},
		'{'{FN_EDGE,   32'd0, 32'd0, 32'd0, 1'b1, 32'd4}, 1'b1, OC_EDGE, 32'hFFFFFFFE},
		'{'{FN_SAMPLE, 32'd0, 32'd1000, 32'd14, 1'b1, 32'd0}, 1'b0, OC_BASELINE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'd50, 32'd14, 1'b1, 32'd0}, 1'b1, OC_REBASE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'd60, 32'd3, 1'b1, 32'd0}, 1'b0, OC_BASELINE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0}, 1'b0,
			OC_BASELINE, 32'd0},
		'{'{FN_RESET,  32'h12345678, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b1, OC_RST_REQ, 32'd0},
		'{'{2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF}, 1'b0,
			OC_BASELINE, 32'd0},
		'{'{FN_EDGE,   32'd0, 32'd0, 32'd0, 1'b0, 32'hFFFFFFFF}, 1'b0, OC_BASELINE, 32'd0},
		'{'{FN_SAMPLE, 32'hFFFFFFFF, 32'd7, 32'd9, 1'b0, 32'd0}, 1'b1, OC_RST_DONE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'd7, 32'd9, 1'b0, 32'd0}, 1'b0, OC_BASELINE, 32'd0},
		'{'{FN_EDGE,   32'd0, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b1, OC_EDGE, 32'd0},
		'{'{FN_RESET,  32'd0, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b1, OC_RST_REQ, 32'd0},
		'{'{FN_RESET,  32'd0, 32'd0, 32'd0, 1'b1, 32'd0}, 1'b1, OC_RST_REQ, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0}, 1'b1, OC_RST_DONE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0}, 1'b0,
			OC_BASELINE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0}, 1'b0,
			OC_BASELINE, 32'd0},
		'{'{FN_SAMPLE, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b1, OC_REBASE, 32'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) ticks <= ticks + 1;

	initial begin
		wait (ticks >= LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [SW-1:0] sat_add(logic [SW-1:0] a, logic [31:0] d);
		logic [SW:0] s;
		s = {1'b0, a} + (SW + 1)'(d);
		return s[SW] ? {SW{1'b1}} : s[SW-1:0];
	endfunction

	task automatic account_request(input req_t q, output bit has_tally, output tally_t t);
		logic [1:0]  d;
		logic [31:0] delta;
		logic [31:0] gap;
		logic [31:0] tdiff;
		logic [63:0] wide;
		logic [3:0]  oc;
		logic [31:0] miss;
		has_tally = 1'b1;
		miss = '0;
		oc = OC_BASELINE;
		d = (q.lvl == inflow_cfg) ? DIR_IN : DIR_OUT;
		case (q.fn)
			FN_SAMPLE: begin
				cur_dir = d;
				if (clear_pend) begin
					in_sum = '0;
					out_sum = '0;
					amb_sum = '0;
					net_acc = '0;
					clears = clears + 1;
					clear_time = q.now;
					base_batch = q.batch;
					acct_dir = d;
					base_total = q.total;
					total_ok = 1'b1;
					abs_acc = '0;
					batch_ok = 1'b1;
					clear_pend = 1'b0;
					edge_pend = 1'b0;
					oc = OC_RST_DONE;
				end else begin
					if (!total_ok || q.total < base_total) begin
						base_total = q.total;
						total_ok = 1'b1;
						abs_acc = '0;
					end else begin
						tdiff = q.total - base_total;
						wide = 64'(tdiff) * 64'(MILLI_L_PER_M3);
						abs_acc = wide[ABS_W-1:0];
					end
					if (!batch_ok) begin
						base_batch = q.batch;
						acct_dir = d;
						batch_ok = 1'b1;
						oc = OC_BASELINE;
					end else if (q.batch < base_batch) begin
						base_batch = q.batch;
						acct_dir = d;
						edge_pend = 1'b0;
						oc = OC_REBASE;
					end else begin
						delta = q.batch - base_batch;
						base_batch = q.batch;
						if (edge_pend) begin
							amb_sum = sat_add(amb_sum, delta);
							acct_dir = edge_dir;
							edge_pend = 1'b0;
							oc = OC_EDGE_AMB;
						end else if (d != acct_dir) begin
							amb_sum = sat_add(amb_sum, delta);
							acct_dir = d;
							oc = OC_CHG_AMB;
						end else begin
							if (d == DIR_IN)
								in_sum = sat_add(in_sum, delta);
							else
								out_sum = sat_add(out_sum, delta);
							wide = 64'(in_sum) - 64'(out_sum);
							net_acc = wide[NET_W-1:0];
							oc = (d == DIR_IN) ? OC_INFLOW : OC_OUTFLOW;
						end
					end
				end
			end
			FN_EDGE: begin
				gap = q.seq - seq_seen;
				if (gap == 0)
					gap = 1;
				seq_seen = q.seq;
				miss = gap - 1;
				cur_dir = d;
				if (batch_ok) begin
					edge_dir = d;
					edge_pend = 1'b1;
				end
				oc = OC_EDGE;
			end
			FN_RESET: begin
				clear_pend = 1'b1;
				oc = OC_RST_REQ;
			end
			default: has_tally = 1'b0;
		endcase
		t.inflow = in_sum;
		t.outflow = out_sum;
		t.unclass = amb_sum;
		t.net = net_acc;
		t.absv = abs_acc;
		t.clears = clears;
		t.clear_time = clear_time;
		t.oc = oc;
		t.missed = miss;
		t.bound = edge_pend;
		t.rst = clear_pend;
		t.dir = cur_dir;
	endtask

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errs++;
		$display("mismatch %0s on result %0d: got %0h, want %0h", what, results, got, want);
	endtask

	task automatic push_req(input req_t q, input logic typed, input logic [3:0] oc,
			input logic [31:0] miss);
		int     gap;
		bit     has;
		tally_t t;
		gap = 0;
		while (idle_on && $urandom_range(0, 99) < 31)
			gap++;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func <= q.fn;
		req_if.now_ms <= q.now;
		req_if.batch_ml <= q.batch;
		req_if.meter_total_milli_m3 <= q.total;
		req_if.pin_level <= q.lvl;
		req_if.event_sequence <= q.seq;
		do @(posedge clk); while (!req_if.ready);
		account_request(q, has, t);
		if (has) begin
			if (typed) begin
				t.oc = oc;
				t.missed = miss;
			end
			tally_q.push_back(t);
		end
	endtask

	// request valid is dropped here, in the step of the last acceptance
	task automatic settle();
		req_if.valid <= 1'b0;
		while (tally_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_inflow(input logic lvl);
		cfg_if.valid <= 1'b1;
		cfg_if.inflow_pin <= lvl;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		inflow_cfg = lvl;
	endtask

	task automatic random_phase(input int n);
		req_t q;
		int   done;
		int   pick;
		int   sel;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			q.now = $urandom;
			q.batch = $urandom;
			q.total = $urandom;
			q.lvl = 1'($urandom_range(0, 1));
			q.seq = $urandom;
			if (pick < 70) begin
				q.fn = FN_SAMPLE;
				sel = $urandom_range(0, 99);
				if (sel < 85)
					g_batch = g_batch + $urandom_range(0, 4000);
				else if (sel < 95)
					g_batch = $urandom;
				else
					g_batch = g_batch - $urandom_range(1, 100);
				sel = $urandom_range(0, 99);
				if (sel < 90)
					g_total = g_total + $urandom_range(0, 5);
				else if (sel < 97)
					g_total = $urandom;
				else
					g_total = g_total - $urandom_range(1, 3);
				if ($urandom_range(0, 99) < 8)
					g_lvl = ~g_lvl;
				q.batch = g_batch;
				q.total = g_total;
				q.lvl = g_lvl;
			end else if (pick < 85) begin
				q.fn = FN_EDGE;
				sel = $urandom_range(0, 99);
				if (sel < 80)
					g_seq = g_seq + $urandom_range(1, 3);
				else if (sel >= 90)
					g_seq = $urandom;
				q.seq = g_seq;
				if ($urandom_range(0, 1))
					g_lvl = ~g_lvl;
				q.lvl = g_lvl;
			end else if (pick < 93) begin
				q.fn = FN_RESET;
			end else begin
				q.fn = 2'd3;
			end
			push_req(q, 1'b0, OC_BASELINE, '0);
			if (q.fn != 2'd3)
				done++;
		end
	endtask

	initial begin
		tally_t got;
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				results++;
				if (tally_q.size() == 0) begin
					flag_mismatch("unexpected result", {60'd0, res_if.outcome}, 64'd0);
				end else begin
					got = tally_q.pop_front();
					if (res_if.inflow_sum !== got.inflow)
						flag_mismatch("inflow_sum", 64'(res_if.inflow_sum),
							64'(got.inflow));
					if (res_if.outflow_sum !== got.outflow)
						flag_mismatch("outflow_sum", 64'(res_if.outflow_sum),
							64'(got.outflow));
					if (res_if.unclassified_sum !== got.unclass)
						flag_mismatch("unclassified_sum", 64'(res_if.unclassified_sum),
							64'(got.unclass));
					if (res_if.net_volume !== got.net)
						flag_mismatch("net_volume", 64'($unsigned(res_if.net_volume)),
							64'(got.net));
					if (res_if.meter_absolute !== got.absv)
						flag_mismatch("meter_absolute", 64'(res_if.meter_absolute),
							64'(got.absv));
					if (res_if.reset_count !== got.clears)
						flag_mismatch("reset_count", 64'(res_if.reset_count),
							64'(got.clears));
					if (res_if.reset_time_ms !== got.clear_time)
						flag_mismatch("reset_time_ms", 64'(res_if.reset_time_ms),
							64'(got.clear_time));
					if (res_if.outcome !== got.oc)
						flag_mismatch("outcome", 64'(res_if.outcome), 64'(got.oc));
					if (res_if.missed_events !== got.missed)
						flag_mismatch("missed_events", 64'(res_if.missed_events),
							64'(got.missed));
					if (res_if.boundary_pending !== got.bound)
						flag_mismatch("boundary_pending", 64'(res_if.boundary_pending),
							64'(got.bound));
					if (res_if.rst_pending !== got.rst)
						flag_mismatch("rst_pending", 64'(res_if.rst_pending),
							64'(got.rst));
					if (res_if.direction !== got.dir)
						flag_mismatch("direction", 64'(res_if.direction), 64'(got.dir));
				end
			end
			res_if.ready <= idle_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
		end
	end

	initial begin
		req_t q;
		int   i;
		req_if.valid <= 1'b0;
		req_if.func <= FN_SAMPLE;
		req_if.now_ms <= '0;
		req_if.batch_ml <= '0;
		req_if.meter_total_milli_m3 <= '0;
		req_if.pin_level <= 1'b0;
		req_if.event_sequence <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.inflow_pin <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		write_inflow(1'b0);
		for (i = 0; i < NDIR; i++)
			push_req(plan[i].rq, plan[i].typed, plan[i].oc, plan[i].miss);
		settle();

		write_inflow(1'b1);
		random_phase(650);
		settle();

		write_inflow(1'b0);
		random_phase(650);
		settle();

		// full-scale inflow deltas separated by rebases, no idling
		write_inflow(1'b1);
		idle_on = 1'b0;
		for (i = 0; i < 2 * NSAT; i++) begin
			q.fn = FN_SAMPLE;
			q.now = $urandom;
			q.batch = i[0] ? 32'hFFFFFFFF : 32'h0;
			q.total = 32'(i);
			q.lvl = 1'b1;
			q.seq = $urandom;
			push_req(q, 1'b0, OC_BASELINE, '0);
		end
		settle();

		if (errs == 0 && tally_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> sim.f
rtl/bft_pkg.sv
rtl/bft_ifs.sv
rtl/bft_front.sv
rtl/bft_queue.sv
rtl/bft_back.sv
rtl/bidirectional_flow_totalizer.sv
bench/tb_top.sv
